### sv/phck_pkg.sv
`default_nettype none

package phck_pkg;

  localparam int unsigned HDR_BYTES = 10;
  localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);

  localparam logic [HDR_IDX_W-1:0] POS_ADDR_HI = HDR_IDX_W'(0);
  localparam logic [HDR_IDX_W-1:0] POS_ADDR_LO = HDR_IDX_W'(1);
  localparam logic [HDR_IDX_W-1:0] POS_MODE    = HDR_IDX_W'(4);
  localparam logic [HDR_IDX_W-1:0] POS_SEL     = HDR_IDX_W'(5);
  localparam logic [HDR_IDX_W-1:0] POS_CHECK   = HDR_IDX_W'(6);
  localparam logic [HDR_IDX_W-1:0] POS_LEN_HI  = HDR_IDX_W'(7);
  localparam logic [HDR_IDX_W-1:0] POS_LEN_LO  = HDR_IDX_W'(8);
  localparam logic [HDR_IDX_W-1:0] POS_LINE    = HDR_IDX_W'(HDR_BYTES - 1);

  localparam logic [7:0] MODE_CONFIG  = 8'h01;
  localparam logic [7:0] MODE_RUNTIME = 8'h02;

  localparam logic [1:0] STAGE_CONFIG  = 2'd0;
  localparam logic [1:0] STAGE_RUNTIME = 2'd1;
  localparam logic [1:0] STAGE_OTHER   = 2'd2;

  // two-byte decimal fields: hi*100 + lo
  localparam logic [14:0] DEC_SCALE = 15'd100;
  localparam logic [8:0]  CHECK_MOD = 9'd100;

  typedef struct packed {
    logic        frame_ok;
    logic        checksum_ok;
    logic        address_ok;
    logic [1:0]  stage_code;
    logic [7:0]  selector_byte;
    logic [7:0]  line_byte;
    logic [14:0] data_length;
    logic [14:0] board_address;
  } result_t;

endpackage

`default_nettype wire

### sv/phck_parser.sv
`default_nettype none

module phck_parser (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire [7:0]              rx_byte_i,
  input  wire                    frame_start_i,
  output logic                   emit_o,
  output phck_pkg::result_t      result_o
);
  import phck_pkg::*;

  logic                 in_packet_q, in_packet_d;
  logic                 in_data_q, in_data_d;
  logic [HDR_IDX_W-1:0] idx_q, idx_d;
  logic [14:0]          rem_q, rem_d;
  logic [6:0]           sum_q, sum_d;
  logic [14:0]          board_q, board_d;

  // header fields, written before they are read
  logic [7:0]  addr_hi_q, len_hi_q, mode_q, sel_q, chk_q, line_q;
  logic [14:0] addr_q, len_q;

  logic                 active, data_ph, hdr_ph;
  logic [HDR_IDX_W-1:0] idx;
  logic [8:0]           sum_raw;
  logic [6:0]           sum_new, sum_eff;
  logic                 hdr_end, ck_ok, ad_ok;
  logic [14:0]          dec_val;

  always_comb begin
    active  = frame_start_i | in_packet_q;
    idx     = frame_start_i ? '0 : idx_q;
    data_ph = active & in_data_q & ~frame_start_i;
    hdr_ph  = active & ~data_ph;
    hdr_end = hdr_ph & (idx == POS_LINE);

    sum_raw = {2'b00, sum_q} + {1'b0, rx_byte_i};
    if (sum_raw >= 9'(3 * CHECK_MOD)) begin
      sum_new = 7'(sum_raw - 9'(3 * CHECK_MOD));
    end else if (sum_raw >= 9'(2 * CHECK_MOD)) begin
      sum_new = 7'(sum_raw - 9'(2 * CHECK_MOD));
    end else if (sum_raw >= CHECK_MOD) begin
      sum_new = 7'(sum_raw - CHECK_MOD);
    end else begin
      sum_new = sum_raw[6:0];
    end

    // hi byte was stored one beat earlier (address or length)
    dec_val = ((idx == POS_ADDR_LO) ? {7'b0, addr_hi_q} : {7'b0, len_hi_q}) * DEC_SCALE
              + {7'b0, rx_byte_i};

    emit_o  = (hdr_end & (len_q == '0)) | (data_ph & (rem_q == 15'd1));
    sum_eff = data_ph ? sum_new : sum_q;
    ck_ok   = ({1'b0, sum_eff} == chk_q);
    ad_ok   = (mode_q != MODE_RUNTIME) | (addr_q == board_q);

    result_o.frame_ok      = ck_ok & ad_ok;
    result_o.checksum_ok   = ck_ok;
    result_o.address_ok    = ad_ok;
    if (mode_q == MODE_CONFIG) begin
      result_o.stage_code    = STAGE_CONFIG;
      result_o.board_address = addr_q;
    end else if (mode_q == MODE_RUNTIME) begin
      result_o.stage_code    = STAGE_RUNTIME;
      result_o.board_address = board_q;
    end else begin
      result_o.stage_code    = STAGE_OTHER;
      result_o.board_address = board_q;
    end
    result_o.selector_byte = sel_q;
    result_o.line_byte     = hdr_end ? rx_byte_i : line_q;
    result_o.data_length   = len_q;

    in_packet_d = active;
    in_data_d   = data_ph | hdr_end;
    idx_d       = hdr_ph ? idx + HDR_IDX_W'(1) : idx_q;
    rem_d       = hdr_end ? len_q : (data_ph ? rem_q - 15'd1 : rem_q);
    sum_d       = frame_start_i ? '0 : (data_ph ? sum_new : sum_q);
    board_d     = board_q;
    if (emit_o) begin
      in_packet_d = 1'b0;
      in_data_d   = 1'b0;
      idx_d       = '0;
      sum_d       = '0;
      board_d     = result_o.board_address;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q <= 1'b0;
      in_data_q   <= 1'b0;
      idx_q       <= '0;
      rem_q       <= '0;
      sum_q       <= '0;
      board_q     <= '0;
    end else if (en_i) begin
      in_packet_q <= in_packet_d;
      in_data_q   <= in_data_d;
      idx_q       <= idx_d;
      rem_q       <= rem_d;
      sum_q       <= sum_d;
      board_q     <= board_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && hdr_ph) begin
      case (idx)
        POS_ADDR_HI: addr_hi_q <= rx_byte_i;
        POS_ADDR_LO: addr_q    <= dec_val;
        POS_MODE:    mode_q    <= rx_byte_i;
        POS_SEL:     sel_q     <= rx_byte_i;
        POS_CHECK:   chk_q     <= rx_byte_i;
        POS_LEN_HI:  len_hi_q  <= rx_byte_i;
        POS_LEN_LO:  len_q     <= dec_val;
        POS_LINE:    line_q    <= rx_byte_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/packet_header_check_deframer.sv
// Packet header check deframer.
// Input channel: one received byte per beat (rx_byte_i) with frame_start_i
// marking header byte 0; in_valid_i / in_ready_o. Output channel: one
// report per completed packet (checksum and address verdicts plus parsed
// header fields); out_valid_o / out_ready_i.
// A beat lands in an input register and is parsed from there; if it
// finishes a packet, the report is loaded into the output register that
// drives out_valid_o. Throughput is one byte per cycle unless a
// packet-ending byte waits for the output register; per-byte work is one
// index/count step and a mod-100 add in the parser.
// When the receiver stalls, bytes that finish no packet keep flowing; a
// packet-ending byte waits in the input register until the output register
// frees, and in_ready_o stays low for that whole wait.
// Reset clears the packet state, running sum and stored board address
// (board address reads 0); no report is pending after reset.
`default_nettype none

module packet_header_check_deframer (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  rx_byte_i,
  input  wire         frame_start_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic        frame_ok_o,
  output logic        checksum_ok_o,
  output logic        address_ok_o,
  output logic [1:0]  stage_code_o,
  output logic [7:0]  selector_byte_o,
  output logic [7:0]  line_byte_o,
  output logic [14:0] data_length_o,
  output logic [14:0] board_address_o
);
  import phck_pkg::*;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;
  logic       emit, proc_en;
  result_t    res, out_q;
  logic       out_valid_q;

  phck_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (proc_en),
    .rx_byte_i     (s1_byte_q),
    .frame_start_i (s1_start_q),
    .emit_o        (emit),
    .result_o      (res)
  );

  // only a packet-ending beat needs room in the output register
  assign proc_en    = s1_valid_q & (~emit | ~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | proc_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (proc_en && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q  <= rx_byte_i;
      s1_start_q <= frame_start_i;
    end
    if (proc_en && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_ok_o      = out_q.frame_ok;
  assign checksum_ok_o   = out_q.checksum_ok;
  assign address_ok_o    = out_q.address_ok;
  assign stage_code_o    = out_q.stage_code;
  assign selector_byte_o = out_q.selector_byte;
  assign line_byte_o     = out_q.line_byte;
  assign data_length_o   = out_q.data_length;
  assign board_address_o = out_q.board_address;

endmodule

`default_nettype wire

### tb/sv/tb_packet_header_check_deframer.sv
module tb_packet_header_check_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import phck_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_BEATS = 850;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Tracks the deframer's packet state and keeps the reports it should emit.
  class report_tracker;
    bit [14:0] pos;
    bit [7:0]  hdr [HDR_BYTES];
    bit [6:0]  acc;
    bit [14:0] board;
    bit        open;
    result_t   pending [$];
    int        errors;

    function new();
      pos = '0;
      acc = '0;
      board = '0;
      open = 1'b0;
      errors = 0;
      foreach (hdr[i]) hdr[i] = '0;
    endfunction

    function int unsigned header_len();
      return 32'(hdr[POS_LEN_HI]) * 32'(DEC_SCALE) + 32'(hdr[POS_LEN_LO]);
    endfunction

    function void close_packet();
      result_t   r;
      bit [14:0] addr;
      addr = 15'(32'(hdr[POS_ADDR_HI]) * 32'(DEC_SCALE) + 32'(hdr[POS_ADDR_LO]));
      r.checksum_ok = (32'(acc) == 32'(hdr[POS_CHECK]));
      r.address_ok = 1'b1;
      r.stage_code = STAGE_OTHER;
      if (hdr[POS_MODE] == MODE_CONFIG) begin
        r.stage_code = STAGE_CONFIG;
        board = addr;
      end else if (hdr[POS_MODE] == MODE_RUNTIME) begin
        r.stage_code = STAGE_RUNTIME;
        r.address_ok = (addr == board);
      end
      r.frame_ok = r.checksum_ok & r.address_ok;
      r.selector_byte = hdr[POS_SEL];
      r.line_byte = hdr[POS_LINE];
      r.data_length = 15'(header_len());
      r.board_address = board;
      pending.push_back(r);
      open = 1'b0;
      pos = '0;
      acc = '0;
    endfunction

    function void take_byte(bit [7:0] b, bit start);
      if (start) begin
        open = 1'b1;
        pos = '0;
        acc = '0;
      end
      if (!open) return;
      if (32'(pos) < HDR_BYTES) begin
        hdr[pos] = b;
        pos = pos + 15'd1;
        if (32'(pos) == HDR_BYTES && header_len() == 0) close_packet();
        return;
      end
      acc = 7'((32'(acc) + 32'(b)) % 32'(CHECK_MOD));
      pos = pos + 15'd1;
      if (32'(pos) >= HDR_BYTES + header_len()) close_packet();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic [14:0] got, logic [14:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_report(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report_mismatch("report with nothing pending");
        return;
      end
      want = pending.pop_front();
      compare_field("frame_ok", 15'(got.frame_ok), 15'(want.frame_ok));
      compare_field("checksum_ok", 15'(got.checksum_ok), 15'(want.checksum_ok));
      compare_field("address_ok", 15'(got.address_ok), 15'(want.address_ok));
      compare_field("stage_code", 15'(got.stage_code), 15'(want.stage_code));
      compare_field("selector_byte", 15'(got.selector_byte), 15'(want.selector_byte));
      compare_field("line_byte", 15'(got.line_byte), 15'(want.line_byte));
      compare_field("data_length", got.data_length, want.data_length);
      compare_field("board_address", got.board_address, want.board_address);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  rx_byte_i = '0;
  logic        frame_start_i = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        frame_ok_o;
  logic        checksum_ok_o;
  logic        address_ok_o;
  logic [1:0]  stage_code_o;
  logic [7:0]  selector_byte_o;
  logic [7:0]  line_byte_o;
  logic [14:0] data_length_o;
  logic [14:0] board_address_o;

  report_tracker tracker;
  bit            calm = 1'b0;
  int unsigned   cycles = 0;
  int unsigned   beats = 0;

  packet_header_check_deframer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_ok_o     (frame_ok_o),
    .checksum_ok_o  (checksum_ok_o),
    .address_ok_o   (address_ok_o),
    .stage_code_o   (stage_code_o),
    .selector_byte_o(selector_byte_o),
    .line_byte_o    (line_byte_o),
    .data_length_o  (data_length_o),
    .board_address_o(board_address_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // report sink: check accepted beats, stall at random
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.frame_ok = frame_ok_o;
      got.checksum_ok = checksum_ok_o;
      got.address_ok = address_ok_o;
      got.stage_code = stage_code_o;
      got.selector_byte = selector_byte_o;
      got.line_byte = line_byte_o;
      got.data_length = data_length_o;
      got.board_address = board_address_o;
      tracker.check_report(got);
    end
    out_ready_i <= calm || ($urandom_range(99) >= 30);
  end

  // valid stays up between back-to-back beats; lowered only for a gap
  task automatic send_beat(input bit [7:0] b, input bit start);
    int unsigned gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 30) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    frame_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_byte(b, start);
    beats++;
  endtask

  task automatic send_packet(input bit [7:0] pkt [$], input int unsigned cut);
    for (int unsigned i = 0; i < cut; i++) begin
      send_beat(pkt[i], i == 0);
    end
  endtask

  task automatic wait_reports_done();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending.size() != 0);
  endtask

  task automatic random_packet();
    bit [7:0]    h [HDR_BYTES];
    bit [7:0]    pkt [$];
    bit [7:0]    payload [$];
    bit [7:0]    b;
    int unsigned roll;
    int unsigned len;
    int unsigned total;
    int unsigned cut;
    foreach (h[i]) h[i] = 8'($urandom);
    roll = $urandom_range(99);
    if (roll < 35) h[POS_MODE] = MODE_CONFIG;
    else if (roll < 75) h[POS_MODE] = MODE_RUNTIME;
    if (h[POS_MODE] == MODE_RUNTIME && $urandom_range(99) < 70 &&
        32'(tracker.board) / 100 <= 255) begin
      h[POS_ADDR_HI] = 8'(32'(tracker.board) / 100);
      h[POS_ADDR_LO] = 8'(32'(tracker.board) % 100);
    end
    roll = $urandom_range(99);
    if (roll < 15) begin
      h[POS_LEN_HI] = '0;
      h[POS_LEN_LO] = '0;
    end else if (roll < 96) begin
      h[POS_LEN_HI] = '0;
      h[POS_LEN_LO] = 8'($urandom_range(1, 6));
    end else begin
      h[POS_LEN_HI] = 8'd1;
      h[POS_LEN_LO] = 8'($urandom_range(0, 20));
    end
    len = 32'(h[POS_LEN_HI]) * 100 + 32'(h[POS_LEN_LO]);
    total = 0;
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom);
      total += b;
      payload.push_back(b);
    end
    roll = $urandom_range(99);
    if (roll < 60) h[POS_CHECK] = 8'(total % 100);
    else if (roll < 80) h[POS_CHECK] = 8'($urandom_range(0, 99));
    foreach (h[i]) pkt.push_back(h[i]);
    foreach (payload[i]) pkt.push_back(payload[i]);
    cut = pkt.size();
    // broken packet: cut short so the next start drops it, sometimes with a huge length
    if ($urandom_range(99) < 15) begin
      cut = $urandom_range(1, pkt.size() - 1);
      if ($urandom_range(1)) begin
        pkt[POS_LEN_HI] = 8'($urandom);
        pkt[POS_LEN_LO] = 8'($urandom);
      end
    end
    send_packet(pkt, cut);
    repeat ($urandom_range(0, 2)) send_beat(8'($urandom), 1'b0);
  endtask

  initial begin
    bit [7:0]    pkt [$];
    int unsigned pkt_idx;
    tracker = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle bytes before any start are dropped
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    // config packet at max address, zero length
    pkt = '{8'hFF, 8'hFF, 8'hAA, 8'h55, MODE_CONFIG, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_packet(pkt, pkt.size());
    send_beat(8'h5A, 1'b0);
    // runtime packet, address match, check byte too large to ever match
    pkt = '{8'hFF, 8'hFF, 8'h00, 8'hFF, MODE_RUNTIME, 8'hFF, 8'd150, 8'h00, 8'h01, 8'h00,
            8'd150};
    send_packet(pkt, pkt.size());

    pkt_idx = 0;
    while (beats < RANDOM_BEATS) begin
      if (pkt_idx == 20) wait_reports_done();
      calm = (pkt_idx >= 30 && pkt_idx < 42);
      random_packet();
      pkt_idx++;
    end
    calm = 1'b0;

    wait_reports_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
